// ===== src/led_grayscale_double_buffer_core_assert.svh =====
// assertion macros for the grayscale double buffer core
`ifndef LED_GRAYSCALE_DOUBLE_BUFFER_CORE_ASSERT_SVH
`define LED_GRAYSCALE_DOUBLE_BUFFER_CORE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define LGDB_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define LGDB_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lgdb_pkg.sv =====
// shared constants and codes for the grayscale double buffer core
`timescale 1ns / 1ps

package lgdb_pkg;

  localparam int CH_PER_DEV  = 16;
  localparam int DEVICES_DEF = 2;

  localparam int OP_W    = 2;
  localparam int CH_W    = 5;
  localparam int LEVEL_W = 12;
  localparam int KIND_W  = 2;

  // input operation codes
  localparam logic [OP_W-1:0] OP_SET    = 2'd0;
  localparam logic [OP_W-1:0] OP_COMMIT = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  // result kind codes
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LATCH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WORD   = 2'd2;

endpackage

// ===== src/lgdb_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module lgdb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/led_grayscale_double_buffer_core.sv =====
// top level of the double-buffered grayscale store for chained led pwm drivers
//
//  channel | ports                             | handshake
//  --------+-----------------------------------+----------------------------------------
//  input   | in_op, in_channel, in_level       | beat taken when start & !busy
//  result  | out_kind ... out_last, six fields | out_valid strobe, one cycle, never held
//
// busy: set, refused commit and tick with nothing pending leave busy low; a copying commit
// or a shifting tick holds busy while it walks every store entry, one store entry per cycle
// a shifting tick gives its latch beat, then one word beat per cycle once the first back store read returns
// reset: synchronous, active low; clears the sequencer, the flags and the front valid bits,
// so unwritten front entries read as zero without a clearing pass
// stalls: none, the receiver cannot hold results off
`timescale 1ns / 1ps
`include "led_grayscale_double_buffer_core_assert.svh"

module led_grayscale_double_buffer_core
  import lgdb_pkg::*;
#(
  parameter int DEVICES = DEVICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_op,
  input  logic [CH_W-1:0]    in_channel,
  input  logic [LEVEL_W-1:0] in_level,
  // result channel
  output logic               out_valid,
  output logic [KIND_W-1:0]  out_kind,
  output logic               out_busy_res,
  output logic               out_latched,
  output logic [CH_W-1:0]    out_word_channel,
  output logic [LEVEL_W-1:0] out_word_level,
  output logic               out_last
);

  localparam int CHANNELS = CH_PER_DEV * DEVICES;
  localparam int AW       = $clog2(CHANNELS);
  localparam logic [AW-1:0] CNT_LAST = AW'(CHANNELS - 1);

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_COPY     = 5'b00010,  // reading front store, writing back store
    ST_COPY_END = 5'b00100,  // final back store write
    ST_EMIT     = 5'b01000,  // reading back store, highest channel first
    ST_EMIT_END = 5'b10000   // final word out
  } state_t;

  state_t state_r, state_nxt;

  // shared channel counter and its single adder
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          cnt_down;
  logic [AW-1:0] cnt_step;
  logic [AW-1:0] cnt_sum;

  // read in flight: trails the counter by one register
  logic          rd_pend_r, rd_pend_nxt;
  logic [AW-1:0] rd_ch_r, rd_ch_nxt;
  logic          rd_vld_r, rd_vld_nxt;

  logic pending_r, pending_nxt;
  logic awaiting_r, awaiting_nxt;

  logic [CHANNELS-1:0] front_vld_r, front_vld_nxt;

  // front store port
  logic               fr_we;
  logic [AW-1:0]      fr_waddr;
  logic [LEVEL_W-1:0] fr_rdata;

  // back store port
  logic               bk_we;
  logic [LEVEL_W-1:0] bk_wdata;
  logic [LEVEL_W-1:0] bk_rdata;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic               out_busy_res_r, out_busy_res_nxt;
  logic               out_latched_r, out_latched_nxt;
  logic [CH_W-1:0]    out_word_channel_r, out_word_channel_nxt;
  logic [LEVEL_W-1:0] out_word_level_r, out_word_level_nxt;
  logic               out_last_r, out_last_nxt;

  logic accept;
  logic copy_mode;
  logic emit_mode;

  // assertion terms
  logic word_beat;
  logic last_word;
  logic tick_go;
  logic walk_open;
  logic commit_go;
  logic copy_open;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign copy_mode = (state_r == ST_COPY) || (state_r == ST_COPY_END);
  assign emit_mode = (state_r == ST_EMIT) || (state_r == ST_EMIT_END);

  // counter steps up while copying, down while emitting
  assign cnt_step = cnt_down ? {AW{1'b1}} : AW'(1);
  assign cnt_sum  = cnt_r + cnt_step;

  // set writes go straight to the front store; out-of-range channels are dropped
  assign fr_waddr = AW'(in_channel);
  assign fr_we    = accept && (in_op == OP_SET) &&
                    ({1'b0, in_channel} < (CH_W + 1)'(CHANNELS));

  // back store is loaded in the cycle after each front read; never-set entries give zero
  assign bk_we    = rd_pend_r && copy_mode;
  assign bk_wdata = rd_vld_r ? fr_rdata : '0;

  lgdb_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (CHANNELS)
  ) u_front (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (in_level),
    .raddr (cnt_r),
    .rdata (fr_rdata)
  );

  lgdb_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (CHANNELS)
  ) u_back (
    .clk   (clk),
    .we    (bk_we),
    .waddr (rd_ch_r),
    .wdata (bk_wdata),
    .raddr (cnt_r),
    .rdata (bk_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cnt_down     = 1'b0;
    rd_pend_nxt  = 1'b0;
    rd_ch_nxt    = rd_ch_r;
    rd_vld_nxt   = rd_vld_r;
    pending_nxt  = pending_r;
    awaiting_nxt = awaiting_r;

    front_vld_nxt = front_vld_r;
    if (fr_we) begin
      front_vld_nxt[fr_waddr] = 1'b1;
    end

    out_valid_nxt        = 1'b0;
    out_kind_nxt         = KIND_STATUS;
    out_busy_res_nxt     = 1'b0;
    out_latched_nxt      = 1'b0;
    out_word_channel_nxt = '0;
    out_word_level_nxt   = '0;
    out_last_nxt         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_COMMIT: begin
              out_valid_nxt    = 1'b1;
              out_kind_nxt     = KIND_STATUS;
              out_busy_res_nxt = pending_r;
              out_last_nxt     = 1'b1;
              if (!pending_r) begin
                pending_nxt = 1'b1;
                cnt_nxt     = '0;
                state_nxt   = ST_COPY;
              end
            end
            OP_TICK: begin
              out_valid_nxt   = 1'b1;
              out_kind_nxt    = KIND_LATCH;
              out_latched_nxt = awaiting_r;
              out_last_nxt    = !pending_r;
              awaiting_nxt    = 1'b0;
              if (pending_r) begin
                // flags settle now; no beat is taken until the walk is done
                pending_nxt  = 1'b0;
                awaiting_nxt = 1'b1;
                cnt_nxt      = CNT_LAST;
                state_nxt    = ST_EMIT;
              end
            end
            default: begin
              // set is handled by the front write port, unused op does nothing
            end
          endcase
        end
      end
      ST_COPY: begin
        rd_pend_nxt = 1'b1;
        rd_ch_nxt   = cnt_r;
        rd_vld_nxt  = front_vld_r[cnt_r];
        cnt_down    = 1'b0;
        cnt_nxt     = cnt_sum;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_COPY_END;
        end
      end
      ST_COPY_END: begin
        state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        rd_pend_nxt = 1'b1;
        rd_ch_nxt   = cnt_r;
        cnt_down    = 1'b1;
        cnt_nxt     = cnt_sum;
        if (cnt_r == '0) begin
          state_nxt = ST_EMIT_END;
        end
      end
      ST_EMIT_END: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // word beat from the back store read issued last cycle
    if (rd_pend_r && emit_mode) begin
      out_valid_nxt        = 1'b1;
      out_kind_nxt         = KIND_WORD;
      out_word_channel_nxt = CH_W'(rd_ch_r);
      out_word_level_nxt   = bk_rdata;
      out_last_nxt         = (rd_ch_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      pending_r   <= 1'b0;
      awaiting_r  <= 1'b0;
      front_vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      pending_r   <= pending_nxt;
      awaiting_r  <= awaiting_nxt;
      front_vld_r <= front_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    cnt_r              <= cnt_nxt;
    rd_ch_r            <= rd_ch_nxt;
    rd_vld_r           <= rd_vld_nxt;
    out_kind_r         <= out_kind_nxt;
    out_busy_res_r     <= out_busy_res_nxt;
    out_latched_r      <= out_latched_nxt;
    out_word_channel_r <= out_word_channel_nxt;
    out_word_level_r   <= out_word_level_nxt;
    out_last_r         <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_busy_res     = out_busy_res_r;
  assign out_latched      = out_latched_r;
  assign out_word_channel = out_word_channel_r;
  assign out_word_level   = out_word_level_r;
  assign out_last         = out_last_r;

  assign word_beat = out_valid && (out_kind == KIND_WORD);
  assign last_word = word_beat && out_last;
  assign tick_go   = accept && (in_op == OP_TICK) && pending_r;
  assign walk_open = out_valid && (out_kind == KIND_LATCH) && !out_last && (state_r == ST_EMIT);
  assign commit_go = accept && (in_op == OP_COMMIT) && !pending_r;
  assign copy_open = pending_r && (state_r == ST_COPY) && !out_busy_res;

  // word beats only go out after the flags have marked data as awaiting a latch
  `LGDB_ASSERT_IMP(a_word_awaits, clk, rst_n, word_beat, awaiting_r, "word beat, no latch awaited")
  // the final word beat always carries channel zero
  `LGDB_ASSERT_IMP(a_last_ch0, clk, rst_n, last_word, ~|out_word_channel, "last word not ch 0")
  // a tick with an update pending opens a word walk after its latch beat
  `LGDB_ASSERT_NXT(a_tick_walk, clk, rst_n, tick_go, walk_open, "tick did not start walk")
  // a commit that is not refused leaves an update pending and starts the copy
  `LGDB_ASSERT_NXT(a_commit_copy, clk, rst_n, commit_go, copy_open, "commit did not start copy")

endmodule
